FILE: src/ttw_pkg.sv
package ttw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_TEXT_COLOR = 1'b0;

    localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;
    localparam logic [7:0]  SPACE_CODE       = 8'h20;
    localparam logic [7:0]  NEWLINE_CODE     = 8'h0A;
    localparam logic [15:0] CLEAR_WORD       = 16'h0720;

    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_READ_CELL  = 3'd1;
    localparam logic [2:0] OP_SET_ROW    = 3'd2;
    localparam logic [2:0] OP_SET_COL    = 3'd3;
    localparam logic [2:0] OP_SET_CURSOR = 3'd4;

    typedef struct packed {
        logic busy;
        logic we;
    } t_sweep_stat;

endpackage

FILE: src/ttw_ram.sv
module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ttw_cfg.sv
module ttw_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttw_pkg::PADDR_W-1:0] paddr,
    input  logic [ttw_pkg::PDATA_W-1:0] pwdata,
    output logic [ttw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [7:0]                  o_text_color
);

    logic [7:0] r_text_color;
    logic       w_hit;

    assign w_hit = (paddr[ttw_pkg::PADDR_W-1] == ttw_pkg::REG_TEXT_COLOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= ttw_pkg::TEXT_COLOR_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_text_color <= pwdata[7:0];
        end
    end

    assign prdata       = w_hit ? {(ttw_pkg::PDATA_W - 8)'(0), r_text_color} : '0;
    assign pready       = 1'b1;
    assign o_text_color = r_text_color;

endmodule

FILE: src/ttw_sweep.sv
module ttw_sweep #(
    parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
    parameter int CELLS   = ttw_pkg::DEF_COLUMNS * ttw_pkg::DEF_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_scroll_start,
    input  logic [15:0]              i_fill_word,
    input  logic [15:0]              i_rdata,
    output ttw_pkg::t_sweep_stat     o_stat,
    output logic [$clog2(CELLS)-1:0] o_waddr,
    output logic [15:0]              o_wdata,
    output logic [$clog2(CELLS)-1:0] o_raddr
);

    localparam int AW = $clog2(CELLS);

    typedef enum logic [2:0] {
        SW_CLEAR  = 3'b001,
        SW_IDLE   = 3'b010,
        SW_SCROLL = 3'b100
    } t_sweep_state;

    t_sweep_state r_state, n_state;
    logic [AW:0]  r_k, n_k;
    logic [AW:0]  w_src;

    assign w_src = r_k + (AW+1)'(COLUMNS);

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        o_stat.busy = 1'b1;
        o_stat.we   = 1'b0;
        o_waddr     = AW'(r_k);
        o_wdata     = ttw_pkg::CLEAR_WORD;
        o_raddr     = '0;
        unique case (r_state)
            SW_CLEAR: begin
                o_stat.we = 1'b1;
                if (r_k == (AW+1)'(CELLS - 1)) begin
                    n_state = SW_IDLE;
                    n_k     = '0;
                end else begin
                    n_k = r_k + (AW+1)'(1);
                end
            end
            SW_IDLE: begin
                o_stat.busy = 1'b0;
                if (i_scroll_start) begin
                    n_state = SW_SCROLL;
                    n_k     = '0;
                end
            end
            SW_SCROLL: begin
                if (w_src < (AW+1)'(CELLS)) begin
                    o_raddr = AW'(w_src);
                end
                o_stat.we = (r_k != '0);
                o_waddr   = AW'(r_k - (AW+1)'(1));
                o_wdata   = (r_k <= (AW+1)'(CELLS - COLUMNS)) ? i_rdata : i_fill_word;
                if (r_k == (AW+1)'(CELLS)) begin
                    n_state = SW_IDLE;
                    n_k     = '0;
                end else begin
                    n_k = r_k + (AW+1)'(1);
                end
            end
            default: begin
                n_state = SW_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_CLEAR;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

endmodule

FILE: src/text_terminal_writer_core.sv
// Text terminal writer over a ROWS x COLUMNS store of 16-bit cells
// (character | attribute << 8), kept in one single-port-write, registered-read
// RAM. After reset o_stall stays high while a sweep fills every cell with
// 0x0720. Each item is then taken in the accept cycle, where the cell write
// or read address goes to the RAM and the write position and cursor update,
// and then moves to ST_RESULT, which loads the result register once the
// output is free; o_stall stays high until then. A put char that passes the
// bottom row first runs a sweep that primes the first read, moves every cell
// up one row and fills the last row with spaces in text_color, one cell per
// cycle through the RAM's single write port, and then hands control back.
// text_color sits at byte address 0 of the APB port and may be written only
// while no transfer is in flight.
module text_terminal_writer_core #(
    parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttw_pkg::PADDR_W-1:0] paddr,
    input  logic [ttw_pkg::PDATA_W-1:0] pwdata,
    output logic [ttw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_opcode,
    input  logic [7:0]                  i_char_code,
    input  logic                        i_move_cursor,
    input  logic [6:0]                  i_position_value,
    input  logic [7:0]                  i_cursor_col_arg,
    input  logic [7:0]                  i_cursor_row_arg,
    input  logic [10:0]                 i_cell_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [15:0]                 o_cell_data,
    output logic [15:0]                 o_cursor_position,
    output logic [4:0]                  o_write_row_now,
    output logic [6:0]                  o_write_col_now,
    output logic                        o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCROLL = 3'b010,
        ST_RESULT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [RW-1:0] r_write_row, n_write_row;
    logic [CW-1:0] r_write_col, n_write_col;
    logic [7:0]    r_cursor_row, n_cursor_row;
    logic [7:0]    r_cursor_col, n_cursor_col;
    logic          r_read_ok, n_read_ok;
    logic          r_scrolled, n_scrolled;
    logic [AW-1:0] r_raddr;

    logic          r_out_valid;
    logic [15:0]   r_out_cell;
    logic [15:0]   r_out_cpos;
    logic [4:0]    r_out_row;
    logic [6:0]    r_out_col;
    logic          r_out_scrolled;

    logic          w_accept;
    logic          w_next_line;
    logic          w_cell_we;
    logic          w_out_free;
    logic [AW-1:0] w_cell_addr;
    logic [AW-1:0] w_idx_addr;
    logic [17:0]   w_cpos_full;
    logic [7:0]    w_text_color;

    ttw_pkg::t_sweep_stat w_sweep_stat;
    logic [AW-1:0] w_sweep_waddr;
    logic [15:0]   w_sweep_wdata;
    logic [AW-1:0] w_sweep_raddr;

    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [15:0]   w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic [15:0]   w_ram_rdata;

    ttw_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_text_color (w_text_color)
    );

    ttw_sweep #(
        .COLUMNS (COLUMNS),
        .CELLS   (CELLS)
    ) u_sweep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scroll_start (w_accept && n_scrolled),
        .i_fill_word    ({w_text_color, ttw_pkg::SPACE_CODE}),
        .i_rdata        (w_ram_rdata),
        .o_stat         (w_sweep_stat),
        .o_waddr        (w_sweep_waddr),
        .o_wdata        (w_sweep_wdata),
        .o_raddr        (w_sweep_raddr)
    );

    ttw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_stall  = !((r_state == ST_IDLE) && !w_sweep_stat.busy);
    assign w_accept = i_valid && !o_stall;

    assign w_cell_addr = AW'(AW'(r_write_row) * AW'(COLUMNS) + AW'(r_write_col));
    assign w_idx_addr  = AW'(i_cell_index);

    always_comb begin
        n_write_row  = r_write_row;
        n_write_col  = r_write_col;
        n_cursor_row = r_cursor_row;
        n_cursor_col = r_cursor_col;
        n_read_ok    = 1'b0;
        n_scrolled   = 1'b0;
        w_next_line  = 1'b0;
        w_cell_we    = 1'b0;
        if (w_accept) begin
            unique case (i_opcode)
                ttw_pkg::OP_PUT_CHAR: begin
                    if (i_char_code == ttw_pkg::NEWLINE_CODE) begin
                        w_next_line = 1'b1;
                    end else begin
                        w_cell_we = 1'b1;
                        if (i_move_cursor) begin
                            n_cursor_col = r_cursor_col + 8'd1;
                        end
                        if (r_write_col == CW'(COLUMNS - 1)) begin
                            w_next_line = 1'b1;
                        end else begin
                            n_write_col = r_write_col + CW'(1);
                        end
                    end
                    if (w_next_line) begin
                        n_write_col = '0;
                        if (i_move_cursor) begin
                            n_cursor_col = '0;
                        end
                        if (r_write_row == RW'(ROWS - 1)) begin
                            n_scrolled = 1'b1;
                        end else begin
                            n_write_row = r_write_row + RW'(1);
                            if (i_move_cursor) begin
                                n_cursor_row = r_cursor_row + 8'd1;
                            end
                        end
                    end
                end
                ttw_pkg::OP_READ_CELL: begin
                    n_read_ok = ({21'd0, i_cell_index} < 32'(CELLS));
                end
                ttw_pkg::OP_SET_ROW: begin
                    n_write_row = ({1'b0, i_position_value} < 8'(ROWS)) ?
                                  RW'(i_position_value) : RW'(ROWS - 1);
                end
                ttw_pkg::OP_SET_COL: begin
                    n_write_col = ({2'b0, i_position_value} < 9'(COLUMNS)) ?
                                  CW'(i_position_value) : CW'(COLUMNS - 1);
                end
                ttw_pkg::OP_SET_CURSOR: begin
                    n_cursor_col = i_cursor_col_arg;
                    n_cursor_row = i_cursor_row_arg;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (w_sweep_stat.busy) begin
            w_ram_we    = w_sweep_stat.we;
            w_ram_waddr = w_sweep_waddr;
            w_ram_wdata = w_sweep_wdata;
            w_ram_raddr = w_sweep_raddr;
        end else begin
            w_ram_we    = w_cell_we;
            w_ram_waddr = w_cell_addr;
            w_ram_wdata = {w_text_color, i_char_code};
            w_ram_raddr = (r_state == ST_IDLE) ? w_idx_addr : r_raddr;
        end
    end

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_cpos_full = 18'(r_cursor_row) * 18'(COLUMNS) + 18'(r_cursor_col);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = n_scrolled ? ST_SCROLL : ST_RESULT;
                end
            end
            ST_SCROLL: begin
                if (!w_sweep_stat.busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_write_row  <= '0;
            r_write_col  <= '0;
            r_cursor_row <= '0;
            r_cursor_col <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_write_row  <= n_write_row;
            r_write_col  <= n_write_col;
            r_cursor_row <= n_cursor_row;
            r_cursor_col <= n_cursor_col;
            if ((r_state == ST_RESULT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_ok  <= n_read_ok;
            r_scrolled <= n_scrolled;
            r_raddr    <= w_idx_addr;
        end
        if ((r_state == ST_RESULT) && w_out_free) begin
            r_out_cell     <= r_read_ok ? w_ram_rdata : '0;
            r_out_cpos     <= w_cpos_full[15:0];
            r_out_row      <= 5'(r_write_row);
            r_out_col      <= 7'(r_write_col);
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_cell_data       = r_out_cell;
    assign o_cursor_position = r_out_cpos;
    assign o_write_row_now   = r_out_row;
    assign o_write_col_now   = r_out_col;
    assign o_scrolled        = r_out_scrolled;

endmodule
